// ===== sv/rect_region_scanline_union_assert.svh =====
// Assertion helpers for the region block
`ifndef RECT_REGION_SCANLINE_UNION_ASSERT_SVH
`define RECT_REGION_SCANLINE_UNION_ASSERT_SVH

// same-cycle implication
`define RRSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RRSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/rrsu_pkg.sv =====
package rrsu_pkg;

  localparam logic [2:0] OP_UNION = 3'd0;
  localparam logic [2:0] OP_CLIP  = 3'd1;
  localparam logic [2:0] OP_TEST  = 3'd2;
  localparam logic [2:0] OP_OFFS  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DONE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_READ_RD,
    S_READ_EV,
    S_U_START,
    S_U_EDGE_RD,
    S_U_EDGE_EV,
    S_U_GATH_RD,
    S_U_GATH_EV,
    S_U_INS,
    S_U_INS_EV,
    S_U_MRG_START,
    S_U_MRG_RD,
    S_U_MRG_EV,
    S_U_PL_RD,
    S_U_PL_EV,
    S_U_PL_END,
    S_U_CP_RD,
    S_U_CP_EV
  } state_t;

endpackage

// ===== sv/rrsu_ram.sv =====
module rrsu_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rect_region_scanline_union.sv =====
// Channel  | Handshake            | Payload
// input    | in_valid / in_stall  | op, rectangle, shift, entry index
// result   | out_valid / out_stall| status, hit, region size, entry edges
// One command at a time; in_stall is high from acceptance until the result is registered.
// Union: per band one edge pass and one gather pass over the sources, insertion shifts of
// the band spans and a build-table scan per merged span, then a copy of every entry back;
// the work is bound by the one read port per table.
// rst_n clears the control state and the entry count; tables need no clearing.
// A stalled result holds while the next command is accepted and worked on.
module rect_region_scanline_union #(
  parameter int MAX_RECTS  = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_op,
  input  logic signed [COORD_BITS-1:0] in_left,
  input  logic signed [COORD_BITS-1:0] in_top,
  input  logic signed [COORD_BITS-1:0] in_right,
  input  logic signed [COORD_BITS-1:0] in_bottom,
  input  logic signed [COORD_BITS-1:0] in_shift_x,
  input  logic signed [COORD_BITS-1:0] in_shift_y,
  input  logic [4:0]                   in_entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_hit,
  output logic [5:0]                   out_region_size,
  output logic signed [COORD_BITS-1:0] out_left,
  output logic signed [COORD_BITS-1:0] out_top,
  output logic signed [COORD_BITS-1:0] out_right,
  output logic signed [COORD_BITS-1:0] out_bottom
);
  import rrsu_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int RW  = 4 * C;
  localparam int RAW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW  = $clog2(MAX_RECTS + 1);
  localparam int PAW = $clog2(MAX_RECTS + 1);
  localparam int SW  = $clog2(MAX_RECTS + 2);

  function automatic logic signed [C-1:0] f_l(input logic [RW-1:0] x);
    return x[4*C-1:3*C];
  endfunction
  function automatic logic signed [C-1:0] f_t(input logic [RW-1:0] x);
    return x[3*C-1:2*C];
  endfunction
  function automatic logic signed [C-1:0] f_r(input logic [RW-1:0] x);
    return x[2*C-1:C];
  endfunction
  function automatic logic signed [C-1:0] f_b(input logic [RW-1:0] x);
    return x[C-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic signed [C-1:0] opl_r, opt_r, opr_r, opb_r;
  logic signed [C-1:0] dx_r, dy_r;
  logic [4:0]          idx_r;
  logic [CW-1:0]       cnt_r, cnt_nxt, s_r, s_nxt, bc_r, bc_nxt, pli_r, pli_nxt;
  logic [SW-1:0]       ns_r, ns_nxt;
  logic [PAW-1:0]      j_r, j_nxt, mi_r, mi_nxt;
  logic signed [C-1:0] y1_r, y1_nxt, y2_r, y2_nxt, best_r, best_nxt;
  logic                found_r, found_nxt, hy1_r, hy1_nxt, last_r, last_nxt;
  logic signed [C-1:0] kl_r, kl_nxt, kr_r, kr_nxt;
  logic signed [C-1:0] curl_r, curl_nxt, curr_r, curr_nxt, pdl_r, pdl_nxt, pdr_r, pdr_nxt;
  logic [1:0]          st_r, st_nxt;
  logic                hit_r, hit_nxt;
  logic [RW-1:0]       ord_r, ord_nxt;
  logic                ov_r, ov_nxt;

  logic            r_we, b_we, p_we;
  logic [RAW-1:0]  r_waddr, r_raddr, b_waddr, b_raddr;
  logic [PAW-1:0]  p_waddr, p_raddr;
  logic [RW-1:0]   r_wdata, r_rdata, b_wdata, b_rdata;
  logic [2*C-1:0]  p_wdata, p_rdata;

  rrsu_ram #(.DEPTH(MAX_RECTS), .WIDTH(RW)) u_rtab (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );
  rrsu_ram #(.DEPTH(MAX_RECTS), .WIDTH(RW)) u_btab (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  rrsu_ram #(.DEPTH(MAX_RECTS + 1), .WIDTH(2 * C)) u_spans (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // source: stored entry, or the operand in the last slot
  logic                src_op;
  logic signed [C-1:0] src_l, src_t, src_r, src_b;
  assign src_op = (s_r == cnt_r);
  assign src_l  = src_op ? opl_r : f_l(r_rdata);
  assign src_t  = src_op ? opt_r : f_t(r_rdata);
  assign src_r  = src_op ? opr_r : f_r(r_rdata);
  assign src_b  = src_op ? opb_r : f_b(r_rdata);

  // smallest edge above y1 (or overall on the first pass)
  logic                ok_t, tk_t, f1, ok_b, tk_b, found_n;
  logic signed [C-1:0] b1, best_n;
  assign ok_t    = !hy1_r || (src_t > y1_r);
  assign tk_t    = ok_t && (!found_r || (src_t < best_r));
  assign b1      = tk_t ? src_t : best_r;
  assign f1      = found_r || tk_t;
  assign ok_b    = !hy1_r || (src_b > y1_r);
  assign tk_b    = ok_b && (!f1 || (src_b < b1));
  assign best_n  = tk_b ? src_b : b1;
  assign found_n = f1 || tk_b;

  // intersection with the operand
  logic signed [C-1:0] il, it, ir, ib;
  logic                ine;
  assign il  = (f_l(r_rdata) > opl_r) ? f_l(r_rdata) : opl_r;
  assign it  = (f_t(r_rdata) > opt_r) ? f_t(r_rdata) : opt_r;
  assign ir  = (f_r(r_rdata) < opr_r) ? f_r(r_rdata) : opr_r;
  assign ib  = (f_b(r_rdata) < opb_r) ? f_b(r_rdata) : opb_r;
  assign ine = (ir > il) && (ib > it);

  logic signed [C-1:0] pl_d, pr_d;
  assign pl_d = p_rdata[2*C-1:C];
  assign pr_d = p_rdata[C-1:0];

  logic mi_last;
  assign mi_last = ((SW'(mi_r) + SW'(1)) == ns_r);

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    logic ret;
    ret       = 1'b0;
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    bc_nxt    = bc_r;
    pli_nxt   = pli_r;
    ns_nxt    = ns_r;
    j_nxt     = j_r;
    mi_nxt    = mi_r;
    y1_nxt    = y1_r;
    y2_nxt    = y2_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    hy1_nxt   = hy1_r;
    last_nxt  = last_r;
    kl_nxt    = kl_r;
    kr_nxt    = kr_r;
    curl_nxt  = curl_r;
    curr_nxt  = curr_r;
    pdl_nxt   = pdl_r;
    pdr_nxt   = pdr_r;
    st_nxt    = st_r;
    hit_nxt   = hit_r;
    ord_nxt   = ord_r;
    ov_nxt    = ov_r && out_stall;
    r_we      = 1'b0;
    r_waddr   = RAW'(s_r);
    r_wdata   = r_rdata;
    r_raddr   = RAW'(s_r);
    b_we      = 1'b0;
    b_waddr   = RAW'(pli_r);
    b_wdata   = b_rdata;
    b_raddr   = RAW'(pli_r);
    p_we      = 1'b0;
    p_waddr   = j_r;
    p_wdata   = {kl_r, kr_r};
    p_raddr   = mi_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_op;
          st_nxt  = ST_OK;
          hit_nxt = 1'b0;
          ord_nxt = '0;
          s_nxt   = '0;
          bc_nxt  = '0;
          unique case (in_op) inside
            OP_UNION: state_nxt = S_U_START;
            OP_CLIP, OP_TEST, OP_OFFS: state_nxt = S_SCAN_RD;
            OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            OP_READ: state_nxt = S_READ_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (s_r == cnt_r) begin
          if (op_r == OP_CLIP) begin
            cnt_nxt = bc_r;
            hit_nxt = (bc_r != '0);
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        case (op_r)
          OP_CLIP: begin
            if (ine) begin
              r_we    = 1'b1;
              r_waddr = RAW'(bc_r);
              r_wdata = {il, it, ir, ib};
              bc_nxt  = bc_r + CW'(1);
            end
          end
          OP_TEST: begin
            if (ine) hit_nxt = 1'b1;
          end
          default: begin
            r_we    = 1'b1;
            r_wdata = {f_l(r_rdata) + dx_r, f_t(r_rdata) + dy_r,
                       f_r(r_rdata) + dx_r, f_b(r_rdata) + dy_r};
          end
        endcase
        s_nxt     = s_r + CW'(1);
        state_nxt = S_SCAN_RD;
      end
      S_READ_RD: begin
        r_raddr = RAW'(idx_r);
        if ((32'(idx_r) < 32'(cnt_r)) && (32'(idx_r) < MAX_RECTS)) begin
          state_nxt = S_READ_EV;
        end else begin
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end
      end
      S_READ_EV: begin
        ord_nxt   = r_rdata;
        state_nxt = S_DONE;
      end
      S_U_START: begin
        if ((opr_r <= opl_r) || (opb_r <= opt_r)) begin
          state_nxt = S_DONE;
        end else if (cnt_r == '0) begin
          r_we      = 1'b1;
          r_waddr   = '0;
          r_wdata   = {opl_r, opt_r, opr_r, opb_r};
          cnt_nxt   = CW'(1);
          state_nxt = S_DONE;
        end else begin
          hy1_nxt   = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_U_EDGE_RD;
        end
      end
      S_U_EDGE_RD: state_nxt = S_U_EDGE_EV;
      S_U_EDGE_EV: begin
        best_nxt  = best_n;
        found_nxt = found_n;
        if (src_op) begin
          s_nxt     = '0;
          found_nxt = 1'b0;
          if (!hy1_r) begin
            y1_nxt    = best_n;
            hy1_nxt   = 1'b1;
            state_nxt = S_U_EDGE_RD;
          end else if (!found_n) begin
            state_nxt = S_U_CP_RD;
          end else begin
            y2_nxt    = best_n;
            ns_nxt    = '0;
            state_nxt = S_U_GATH_RD;
          end
        end else begin
          s_nxt     = s_r + CW'(1);
          state_nxt = S_U_EDGE_RD;
        end
      end
      S_U_GATH_RD: state_nxt = S_U_GATH_EV;
      S_U_GATH_EV: begin
        if ((src_b > y1_r) && (src_t < y2_r)) begin
          kl_nxt    = src_l;
          kr_nxt    = src_r;
          j_nxt     = PAW'(ns_r);
          state_nxt = S_U_INS;
        end else if (src_op) begin
          state_nxt = S_U_MRG_START;
        end else begin
          s_nxt     = s_r + CW'(1);
          state_nxt = S_U_GATH_RD;
        end
      end
      S_U_INS: begin
        p_raddr = j_r - PAW'(1);
        if (j_r == '0) begin
          p_we   = 1'b1;
          ns_nxt = ns_r + SW'(1);
          if (src_op) begin
            state_nxt = S_U_MRG_START;
          end else begin
            s_nxt     = s_r + CW'(1);
            state_nxt = S_U_GATH_RD;
          end
        end else begin
          state_nxt = S_U_INS_EV;
        end
      end
      S_U_INS_EV: begin
        p_we = 1'b1;
        if ((pl_d > kl_r) || ((pl_d == kl_r) && (pr_d > kr_r))) begin
          p_wdata   = p_rdata;
          j_nxt     = j_r - PAW'(1);
          state_nxt = S_U_INS;
        end else begin
          ns_nxt = ns_r + SW'(1);
          if (src_op) begin
            state_nxt = S_U_MRG_START;
          end else begin
            s_nxt     = s_r + CW'(1);
            state_nxt = S_U_GATH_RD;
          end
        end
      end
      S_U_MRG_START: begin
        if (ns_r == '0) begin
          y1_nxt    = y2_r;
          found_nxt = 1'b0;
          s_nxt     = '0;
          state_nxt = S_U_EDGE_RD;
        end else begin
          mi_nxt    = '0;
          state_nxt = S_U_MRG_RD;
        end
      end
      S_U_MRG_RD: state_nxt = S_U_MRG_EV;
      S_U_MRG_EV: begin
        if ((mi_r != '0) && (pl_d > curr_r)) begin
          pdl_nxt   = pl_d;
          pdr_nxt   = pr_d;
          last_nxt  = 1'b0;
          pli_nxt   = '0;
          state_nxt = S_U_PL_RD;
        end else begin
          if (mi_r == '0) begin
            curl_nxt = pl_d;
            curr_nxt = pr_d;
          end else if ((pl_d == curr_r) || (pr_d > curr_r)) begin
            curr_nxt = pr_d;
          end
          if (mi_last) begin
            last_nxt  = 1'b1;
            pli_nxt   = '0;
            state_nxt = S_U_PL_RD;
          end else begin
            mi_nxt    = mi_r + PAW'(1);
            state_nxt = S_U_MRG_RD;
          end
        end
      end
      S_U_PL_RD: begin
        state_nxt = (pli_r == bc_r) ? S_U_PL_END : S_U_PL_EV;
      end
      S_U_PL_EV: begin
        if ((f_b(b_rdata) == y1_r) && (f_l(b_rdata) == curl_r) &&
            (f_r(b_rdata) == curr_r)) begin
          b_we    = 1'b1;
          b_wdata = {f_l(b_rdata), f_t(b_rdata), f_r(b_rdata), y2_r};
          ret     = 1'b1;
        end else begin
          pli_nxt   = pli_r + CW'(1);
          state_nxt = S_U_PL_RD;
        end
      end
      S_U_PL_END: begin
        if (bc_r == CW'(MAX_RECTS)) begin
          st_nxt    = ST_OVF;
          state_nxt = S_DONE;
        end else begin
          b_we    = 1'b1;
          b_waddr = RAW'(bc_r);
          b_wdata = {curl_r, y1_r, curr_r, y2_r};
          bc_nxt  = bc_r + CW'(1);
          ret     = 1'b1;
        end
      end
      S_U_CP_RD: begin
        b_raddr   = RAW'(s_r);
        state_nxt = S_U_CP_EV;
      end
      S_U_CP_EV: begin
        r_we    = 1'b1;
        r_wdata = b_rdata;
        if ((s_r + CW'(1)) == bc_r) begin
          cnt_nxt   = bc_r;
          state_nxt = S_DONE;
        end else begin
          s_nxt     = s_r + CW'(1);
          state_nxt = S_U_CP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // return from placing a merged span
    if (ret) begin
      if (last_r) begin
        y1_nxt    = y2_r;
        found_nxt = 1'b0;
        s_nxt     = '0;
        state_nxt = S_U_EDGE_RD;
      end else begin
        curl_nxt = pdl_r;
        curr_nxt = pdr_r;
        if (mi_last) begin
          last_nxt  = 1'b1;
          pli_nxt   = '0;
          state_nxt = S_U_PL_RD;
        end else begin
          mi_nxt    = mi_r + PAW'(1);
          state_nxt = S_U_MRG_RD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      opl_r <= in_left;
      opt_r <= in_top;
      opr_r <= in_right;
      opb_r <= in_bottom;
      dx_r  <= in_shift_x;
      dy_r  <= in_shift_y;
      idx_r <= in_entry_index;
    end
    op_r    <= op_nxt;
    s_r     <= s_nxt;
    bc_r    <= bc_nxt;
    pli_r   <= pli_nxt;
    ns_r    <= ns_nxt;
    j_r     <= j_nxt;
    mi_r    <= mi_nxt;
    y1_r    <= y1_nxt;
    y2_r    <= y2_nxt;
    best_r  <= best_nxt;
    found_r <= found_nxt;
    hy1_r   <= hy1_nxt;
    last_r  <= last_nxt;
    kl_r    <= kl_nxt;
    kr_r    <= kr_nxt;
    curl_r  <= curl_nxt;
    curr_r  <= curr_nxt;
    pdl_r   <= pdl_nxt;
    pdr_r   <= pdr_nxt;
    st_r    <= st_nxt;
    hit_r   <= hit_nxt;
    ord_r   <= ord_nxt;
    if ((state_r == S_DONE) && (!ov_r || !out_stall)) begin
      out_status      <= st_r;
      out_hit         <= hit_r;
      out_region_size <= 6'(cnt_r);
      out_left        <= f_l(ord_r);
      out_top         <= f_t(ord_r);
      out_right       <= f_r(ord_r);
      out_bottom      <= f_b(ord_r);
    end
  end

  assign out_valid = ov_r;

`include "rect_region_scanline_union_assert.svh"

  `RRSU_ASSERT_NOW(a_cnt_max, 1'b1, cnt_r <= CW'(MAX_RECTS))
  `RRSU_ASSERT_NOW(a_bc_max, state_r != S_IDLE, bc_r <= CW'(MAX_RECTS))
  `RRSU_ASSERT_NOW(a_busy_stall, state_r != S_IDLE, in_stall)
  `RRSU_ASSERT_NEXT(a_acc_busy, in_acc, state_r != S_IDLE)

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrsu_pkg::*;

  localparam int NRECT = 32;
  localparam int IDLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    int l, t, r, b;
  } box_t;

  typedef struct {
    logic [2:0] op;
    int l, t, r, b, dx, dy;
    logic [4:0] idx;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic        hit;
    logic [5:0]  size;
    logic [15:0] l, t, r, b;
  } reply_t;

  typedef struct {
    request_t req;
    bit       typed;
    reply_t   rep;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_op = '0;
  logic signed [15:0] in_left = '0, in_top = '0, in_right = '0, in_bottom = '0;
  logic signed [15:0] in_shift_x = '0, in_shift_y = '0;
  logic [4:0] in_entry_index = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic out_hit;
  logic [5:0] out_region_size;
  logic signed [15:0] out_left, out_top, out_right, out_bottom;

  rect_region_scanline_union dut (.*);

  always #6 clk = ~clk;

  box_t   region[NRECT];
  int     region_n = 0;
  reply_t pending_replies[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     idle_cycles = 0;

  function automatic int wrap16(int v);
    logic [15:0] w;
    w = v[15:0];
    return int'($signed(w));
  endfunction

  function automatic bit box_empty(box_t x);
    return x.r <= x.l || x.b <= x.t;
  endfunction

  // scanline rebuild; returns overflow status and leaves region untouched on overflow
  function automatic logic [1:0] merge_box(box_t rc);
    box_t src[$];
    box_t built[$];
    box_t nb;
    int edges[$];
    int sl[$], sr[$];
    int y1, y2, cl, cr, k, j;
    bit found;
    if (box_empty(rc)) return ST_OK;
    if (region_n == 0) begin
      region[0] = rc;
      region_n = 1;
      return ST_OK;
    end
    for (int i = 0; i < region_n; i++) src.insert(src.size(), region[i]);
    src.insert(src.size(), rc);
    foreach (src[i]) begin
      for (int s = 0; s < 2; s++) begin
        k = s ? src[i].b : src[i].t;
        j = 0;
        while (j < edges.size() && edges[j] < k) j++;
        if (!(j < edges.size() && edges[j] == k)) edges.insert(j, k);
      end
    end
    for (int e = 0; e + 1 < edges.size(); e++) begin
      y1 = edges[e];
      y2 = edges[e+1];
      sl.delete();
      sr.delete();
      foreach (src[i]) begin
        if (src[i].b <= y1 || src[i].t >= y2) continue;
        j = 0;
        while (j < sl.size() && (sl[j] < src[i].l || (sl[j] == src[i].l && sr[j] <= src[i].r)))
          j++;
        sl.insert(j, src[i].l);
        sr.insert(j, src[i].r);
      end
      if (sl.size() == 0) continue;
      cl = sl[0];
      cr = sr[0];
      for (int i = 1; i <= sl.size(); i++) begin
        if (i < sl.size() && sl[i] <= cr) begin
          // a span starting exactly at the running right edge takes its right edge
          if (sl[i] == cr || sr[i] > cr) cr = sr[i];
          continue;
        end
        found = 0;
        foreach (built[p]) begin
          if (!found && built[p].b == y1 && built[p].l == cl && built[p].r == cr) begin
            built[p].b = y2;
            found = 1;
          end
        end
        if (!found) begin
          if (built.size() >= NRECT) return ST_OVF;
          nb = '{cl, y1, cr, y2};
          built.insert(built.size(), nb);
        end
        if (i < sl.size()) begin
          cl = sl[i];
          cr = sr[i];
        end
      end
    end
    foreach (built[i]) region[i] = built[i];
    region_n = built.size();
    return ST_OK;
  endfunction

  function automatic reply_t region_apply(request_t q);
    reply_t a;
    box_t rc, x;
    int n;
    a = '{ST_OK, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    rc = '{q.l, q.t, q.r, q.b};
    case (q.op)
      OP_UNION: a.status = merge_box(rc);
      OP_CLIP, OP_TEST: begin
        n = 0;
        for (int i = 0; i < region_n; i++) begin
          x.l = region[i].l > rc.l ? region[i].l : rc.l;
          x.t = region[i].t > rc.t ? region[i].t : rc.t;
          x.r = region[i].r < rc.r ? region[i].r : rc.r;
          x.b = region[i].b < rc.b ? region[i].b : rc.b;
          if (!box_empty(x)) begin
            if (q.op == OP_CLIP) region[n] = x;
            n++;
          end
        end
        if (q.op == OP_CLIP) region_n = n;
        a.hit = n != 0;
      end
      OP_OFFS:
        for (int i = 0; i < region_n; i++) begin
          region[i].l = wrap16(region[i].l + q.dx);
          region[i].r = wrap16(region[i].r + q.dx);
          region[i].t = wrap16(region[i].t + q.dy);
          region[i].b = wrap16(region[i].b + q.dy);
        end
      OP_CLEAR: region_n = 0;
      OP_READ:
        if (q.idx < region_n) begin
          a.l = region[q.idx].l[15:0];
          a.t = region[q.idx].t[15:0];
          a.r = region[q.idx].r[15:0];
          a.b = region[q.idx].b[15:0];
        end else begin
          a.status = ST_RANGE;
        end
      default: ;
    endcase
    a.size = region_n[5:0];
    return a;
  endfunction

  task automatic issue(request_t q, bit typed, reply_t rep);
    reply_t predicted;
    in_valid <= 1'b1;
    in_op <= q.op;
    in_left <= q.l[15:0];
    in_top <= q.t[15:0];
    in_right <= q.r[15:0];
    in_bottom <= q.b[15:0];
    in_shift_x <= q.dx[15:0];
    in_shift_y <= q.dy[15:0];
    in_entry_index <= q.idx;
    do @(posedge clk); while (in_stall);
    predicted = region_apply(q);
    pending_replies.insert(pending_replies.size(), typed ? rep : predicted);
    // bursts: usually chain the next request, sometimes pause
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic request_t mkreq(logic [2:0] op, int l, int t, int r, int b,
                                     int dx = 0, int dy = 0, int idx = 0);
    request_t q;
    q = '{op, l, t, r, b, dx, dy, idx[4:0]};
    return q;
  endfunction

  function automatic int coord();
    return ($urandom_range(0, 9) == 0) ? wrap16($urandom) : $urandom_range(0, 48);
  endfunction

  function automatic request_t random_req();
    request_t q;
    int pick, l, t;
    pick = $urandom_range(0, 99);
    l = coord();
    t = coord();
    q = mkreq(OP_UNION, l, t, wrap16(l + $urandom_range(0, 12)), wrap16(t + $urandom_range(0, 12)),
              wrap16($urandom), wrap16($urandom), $urandom_range(0, 31));
    if ($urandom_range(0, 9) == 0) begin
      q.r = coord();
      q.b = coord();
    end
    if (pick >= 45) q.op = OP_READ;
    if (pick >= 45 && $urandom_range(0, 3) != 0) q.idx = 5'($urandom_range(0, region_n));
    if (pick >= 65) q.op = OP_TEST;
    if (pick >= 75) q.op = OP_CLIP;
    if (pick >= 82) begin
      q.op = OP_OFFS;
      if ($urandom_range(0, 1)) begin
        q.dx = $urandom_range(0, 8) - 4;
        q.dy = $urandom_range(0, 8) - 4;
      end
    end
    if (pick >= 90) q.op = OP_CLEAR;
    if (pick >= 97) q.op = pick[0] ? OP_SPARE6 : OP_SPARE7;
    return q;
  endfunction

  row_t   directed[$];
  reply_t none;

  initial begin
    none = '{ST_OK, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    directed = '{
      '{mkreq(OP_READ, 0, 0, 0, 0), 1, '{ST_RANGE, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{mkreq(OP_CLIP, 0, 0, 9, 9), 1, none},
      '{mkreq(OP_TEST, 0, 0, 9, 9), 1, none},
      '{mkreq(OP_UNION, 5, 5, 5, 9), 1, none},
      '{mkreq(OP_UNION, -32768, -32768, 32767, 32767), 1,
        '{ST_OK, 1'b0, 6'd1, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{mkreq(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1,
        '{ST_OK, 1'b0, 6'd1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff}},
      '{mkreq(OP_READ, 0, 0, 0, 0, 0, 0, 31), 1,
        '{ST_RANGE, 1'b0, 6'd1, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{mkreq(OP_OFFS, 0, 0, 0, 0, 1, 1), 0, none},
      '{mkreq(OP_READ, 0, 0, 0, 0, 0, 0, 0), 0, none},
      '{mkreq(OP_CLEAR, 0, 0, 0, 0), 1, none},
      '{mkreq(OP_UNION, 0, 0, 10, 10), 1, '{ST_OK, 1'b0, 6'd1, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{mkreq(OP_UNION, 10, 0, 20, 5), 0, none},
      '{mkreq(OP_UNION, 0, 20, 5, 30), 0, none},
      '{mkreq(OP_UNION, 0, 20, 3, 25), 0, none},
      '{mkreq(OP_UNION, 6, 22, 9, 40), 0, none},
      '{mkreq(OP_TEST, 100, 100, 200, 200), 0, none},
      '{mkreq(OP_TEST, 2, 2, 3, 3), 0, none},
      '{mkreq(OP_CLIP, 2, 2, 15, 25), 0, none},
      '{mkreq(OP_READ, 0, 0, 0, 0, 0, 0, 1), 0, none},
      '{mkreq(OP_OFFS, 0, 0, 0, 0, -32768, 32767), 0, none},
      '{mkreq(OP_READ, 0, 0, 0, 0, 0, 0, 0), 0, none},
      '{mkreq(OP_SPARE6, 1, 1, 2, 2), 0, none},
      '{mkreq(OP_SPARE7, 1, 1, 2, 2), 0, none},
      '{mkreq(OP_CLIP, 500, 500, 600, 600), 0, none}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) issue(directed[i].req, directed[i].typed, directed[i].rep);
    // diagonal boxes each need their own entry: the 33rd union overflows
    issue(mkreq(OP_CLEAR, 0, 0, 0, 0), 0, none);
    for (int i = 0; i < NRECT + 1; i++) issue(mkreq(OP_UNION, 2*i, 2*i, 2*i+1, 2*i+1), 0, none);
    issue(mkreq(OP_READ, 0, 0, 0, 0, 0, 0, 31), 0, none);
    issue(mkreq(OP_CLEAR, 0, 0, 0, 0), 0, none);
    for (int i = 0; i < 100; i++) issue(random_req(), 0, none);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // receiver: one long hold-off, then stall modes drawn at random: none, sparse or heavy
  initial begin
    int mode;
    wait (results_seen >= 40);
    @(posedge clk);
    out_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        out_stall <= (mode == 1) ? ($urandom_range(0, 3) == 0)
                   : (mode == 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status || out_hit !== want.hit ||
            out_region_size !== want.size || out_left !== want.l || out_top !== want.t ||
            out_right !== want.r || out_bottom !== want.b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d hit=%0d n=%0d (%h %h %h %h) got st=%0d hit=%0d n=%0d (%h %h %h %h)",
                     want.status, want.hit, want.size, want.l, want.t, want.r, want.b,
                     out_status, out_hit, out_region_size, out_left, out_top, out_right,
                     out_bottom);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rrsu_pkg.sv
sv/rrsu_ram.sv
sv/rect_region_scanline_union.sv
test/testbench.sv
